>>> rtl/core/frm_pkg.sv
// Shared sizes, constants and interface structs of the frame rate meter and limiter.
// Used by frm_ring, frm_div and frame_rate_meter_limiter; depends on nothing else.
package frm_pkg;

  // Depth of the frame time ring.
  localparam int SAMPLES = 10;

  localparam int TICK_W   = 32;
  localparam int FRAME_W  = 16;
  localparam int FPS_W    = 18;
  localparam int DELAY_W  = 10;
  localparam int MAXFPS_W = 10;
  localparam int PROD_W   = TICK_W + MAXFPS_W;

  localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int SUM_W  = $clog2(SAMPLES * 65535 + 1);

  localparam int FPS_MAX_Q8     = 256000;
  localparam int FPS_DEFAULT_Q8 = 15360;
  localparam int MS_PER_S       = 1000;
  localparam int MAXFPS_RESET   = 60;

  // Dividend width covers 256000 * SAMPLES; the divisor is the ring sum.
  localparam int NUM_W     = $clog2(FPS_MAX_Q8 * SAMPLES + 1);
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_MAX_FPS = 1'b0;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [FRAME_W-1:0] wr_data;
  } frm_ring_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } frm_div_req_t;

endpackage

>>> rtl/core/frame_rate_meter_limiter.sv
// Top level of the frame rate meter and limiter: event sequencer, ring sum and limiter.
// Depends on frm_pkg, frm_ring (frame time memory) and frm_div (serial divider).
//
// Usage. Frame events arrive on the in_ channel (in_valid, in_stall, in_func,
// in_now_ms). A frame begin (in_func low) latches the tick as the start of the
// busy time and gives no result. A frame end gives one result transfer on
// the out_ channel: the time since the previous end (saturated to 16 bits,
// zero on the first end), the rate averaged over the last SAMPLES frame
// times in Q.8 frames per second, and the delay that holds the rate at or
// below max_fps.
// Frame end processing. A frame end reads the old ring entry from the
// registered memory output, updates the running sum, then runs two
// divisions in turn on the one serial divider, the rate first and then the
// period (start, NUM_W steps and the done strobe). One event is handled at
// a time; in_stall is high while an end event is being worked on, so the
// next event is taken only once the result has gone to the output register.
// Stalls and reset. The result waits in an output register while out_stall is
// high, and the block keeps taking events meanwhile; only a second result
// waits for the register to drain. Synchronous reset empties the ring, clears
// the sum, count, slot and ticks, and sets max_fps to 60. The register
// max_fps is written through the APB port at address 0.
module frame_rate_meter_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Event channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [frm_pkg::TICK_W-1:0]    in_now_ms,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [frm_pkg::FRAME_W-1:0]   out_frame_ms,
  output logic [frm_pkg::FPS_W-1:0]     out_fps_q8,
  output logic [frm_pkg::DELAY_W-1:0]   out_delay_ms,
  // Configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [frm_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [frm_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [frm_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RATE_GO,
    S_RATE_WAIT,
    S_PER_GO,
    S_PER_WAIT,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [frm_pkg::MAXFPS_W-1:0]    max_fps_r, max_fps_nxt;
  logic [frm_pkg::TICK_W-1:0]      start_tick_r, start_tick_nxt;
  logic [frm_pkg::TICK_W-1:0]      last_end_r, last_end_nxt;
  logic                            seen_end_r, seen_end_nxt;
  logic [frm_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic [frm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [frm_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [frm_pkg::FRAME_W-1:0]     frame_r, frame_nxt;
  logic [frm_pkg::TICK_W-1:0]      busy_r, busy_nxt;
  logic [frm_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic [frm_pkg::FPS_W-1:0]       fps_r, fps_nxt;
  logic [frm_pkg::DELAY_W-1:0]     delay_r, delay_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [frm_pkg::FRAME_W-1:0]     out_frame_r, out_frame_nxt;
  logic [frm_pkg::FPS_W-1:0]       out_fps_r, out_fps_nxt;
  logic [frm_pkg::DELAY_W-1:0]     out_delay_r, out_delay_nxt;

  logic                            in_xfer;
  logic                            cfg_wr;
  logic                            ring_full;
  logic [frm_pkg::TICK_W-1:0]      elapsed;
  logic [frm_pkg::FRAME_W-1:0]     old_frame;
  logic [frm_pkg::FRAME_W-1:0]     rd_data;
  logic [frm_pkg::TICK_W-1:0]      period;
  logic [frm_pkg::TICK_W-1:0]      slack;
  logic                            div_done;
  logic [frm_pkg::NUM_W-1:0]       div_quot;
  frm_pkg::frm_ring_req_t          ring_req;
  frm_pkg::frm_div_req_t           div_req;

  frm_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  frm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Events are only taken while the sequencer is idle.
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Configuration port: zero-wait, one register at address zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == frm_pkg::REG_MAX_FPS)
                      ? frm_pkg::PDATA_W'(max_fps_r) : '0;

  assign ring_full = (cnt_r >= frm_pkg::CNT_W'(frm_pkg::SAMPLES));
  assign elapsed   = in_now_ms - last_end_r;
  // Slots that were never written hold no defined value, but slots fill in
  // order, so the count tells whether the entry is live.
  assign old_frame = ring_full ? rd_data : '0;
  assign period    = frm_pkg::TICK_W'(div_quot);
  assign slack     = period - busy_r;

  always_comb begin
    state_nxt      = state_r;
    max_fps_nxt    = max_fps_r;
    start_tick_nxt = start_tick_r;
    last_end_nxt   = last_end_r;
    seen_end_nxt   = seen_end_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    frame_nxt      = frame_r;
    busy_nxt       = busy_r;
    prod_nxt       = prod_r;
    fps_nxt        = fps_r;
    delay_nxt      = delay_r;
    out_valid_nxt  = out_valid_r;
    out_frame_nxt  = out_frame_r;
    out_fps_nxt    = out_fps_r;
    out_delay_nxt  = out_delay_r;
    ring_req       = '0;
    div_req        = '0;

    if (cfg_wr && cfg_paddr[2] == frm_pkg::REG_MAX_FPS) begin
      max_fps_nxt = cfg_pwdata[frm_pkg::MAXFPS_W-1:0];
    end

    // The output register drains independently of the sequencer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (!in_func) begin
            start_tick_nxt = in_now_ms;
          end else begin
            if (!seen_end_r) begin
              frame_nxt = '0;
            end else if (|elapsed[frm_pkg::TICK_W-1:frm_pkg::FRAME_W]) begin
              frame_nxt = '1;
            end else begin
              frame_nxt = elapsed[frm_pkg::FRAME_W-1:0];
            end
            seen_end_nxt     = 1'b1;
            last_end_nxt     = in_now_ms;
            busy_nxt         = in_now_ms - start_tick_r;
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = slot_r;
            state_nxt        = S_READ;
          end
        end
      end
      S_READ: begin
        // Old entry is out of the memory now: swap it for the new frame time.
        sum_nxt          = sum_r - frm_pkg::SUM_W'(old_frame)
                           + frm_pkg::SUM_W'(frame_r);
        ring_req.wr_en   = 1'b1;
        ring_req.wr_addr = slot_r;
        ring_req.wr_data = frame_r;
        slot_nxt         = (slot_r == frm_pkg::SLOT_W'(frm_pkg::SAMPLES - 1))
                           ? '0 : slot_r + 1'b1;
        if (!ring_full) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        prod_nxt  = frm_pkg::PROD_W'(busy_r) * frm_pkg::PROD_W'(max_fps_r);
        state_nxt = S_RATE_GO;
      end
      S_RATE_GO: begin
        div_req.start = 1'b1;
        div_req.num   = frm_pkg::NUM_W'(frm_pkg::FPS_MAX_Q8) * frm_pkg::NUM_W'(cnt_r);
        div_req.den   = sum_r;
        state_nxt     = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        if (div_done) begin
          if (sum_r == '0) begin
            fps_nxt = frm_pkg::FPS_W'(frm_pkg::FPS_DEFAULT_Q8);
          end else if (div_quot > frm_pkg::NUM_W'(frm_pkg::FPS_MAX_Q8)) begin
            fps_nxt = frm_pkg::FPS_W'(frm_pkg::FPS_MAX_Q8);
          end else begin
            fps_nxt = div_quot[frm_pkg::FPS_W-1:0];
          end
          state_nxt = S_PER_GO;
        end
      end
      S_PER_GO: begin
        div_req.start = 1'b1;
        div_req.num   = frm_pkg::NUM_W'(frm_pkg::MS_PER_S);
        div_req.den   = frm_pkg::SUM_W'(max_fps_r);
        state_nxt     = S_PER_WAIT;
      end
      S_PER_WAIT: begin
        if (div_done) begin
          // A zero target turns the limiter off; a frame already too long
          // for the target needs no delay.
          if (max_fps_r == '0 || prod_r >= frm_pkg::PROD_W'(frm_pkg::MS_PER_S)) begin
            delay_nxt = '0;
          end else if (period > busy_r) begin
            delay_nxt = slack[frm_pkg::DELAY_W-1:0];
          end else begin
            delay_nxt = '0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = frame_r;
          out_fps_nxt   = fps_r;
          out_delay_nxt = delay_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_fps_r    <= frm_pkg::MAXFPS_W'(frm_pkg::MAXFPS_RESET);
      start_tick_r <= '0;
      last_end_r   <= '0;
      seen_end_r   <= 1'b0;
      slot_r       <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      max_fps_r    <= max_fps_nxt;
      start_tick_r <= start_tick_nxt;
      last_end_r   <= last_end_nxt;
      seen_end_r   <= seen_end_nxt;
      slot_r       <= slot_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    frame_r     <= frame_nxt;
    busy_r      <= busy_nxt;
    prod_r      <= prod_nxt;
    fps_r       <= fps_nxt;
    delay_r     <= delay_nxt;
    out_frame_r <= out_frame_nxt;
    out_fps_r   <= out_fps_nxt;
    out_delay_r <= out_delay_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_frame_ms = out_frame_r;
  assign out_fps_q8   = out_fps_r;
  assign out_delay_ms = out_delay_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= frm_pkg::CNT_W'(frm_pkg::SAMPLES))
    else $error("fill count beyond ring depth");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < 32'(frm_pkg::SAMPLES))
    else $error("write slot outside the ring");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> sum_r == '0)
    else $error("empty ring with nonzero sum");

  a_end_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_func |=> state_r == S_READ)
    else $error("frame end transfer did not start the ring read");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the completion state");

endmodule

>>> rtl/core/frm_ring.sv
// Ring of recent frame times: a single-port-read, single-port-write synchronous memory.
// Depends on frm_pkg for the depth and the request struct.
module frm_ring (
  input  logic                        clk,
  input  frm_pkg::frm_ring_req_t      req,
  output logic [frm_pkg::FRAME_W-1:0] rd_data
);

  logic [frm_pkg::FRAME_W-1:0] mem [frm_pkg::SAMPLES];
  logic [frm_pkg::FRAME_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/frm_div.sv
// Restoring divider, one quotient bit per cycle, shared by the rate and the period.
// Depends on frm_pkg for the operand widths and the request struct.
module frm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  frm_pkg::frm_div_req_t     req,
  output logic                      done,
  output logic [frm_pkg::NUM_W-1:0] quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [frm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [frm_pkg::NUM_W-1:0]     dvd_r, dvd_nxt;
  logic [frm_pkg::SUM_W-1:0]     rem_r, rem_nxt;
  logic [frm_pkg::SUM_W-1:0]     den_r, den_nxt;
  logic [frm_pkg::SUM_W:0]       trial;
  logic                          fits;

  // The dividend register doubles as the quotient: its top bit moves into the
  // remainder and the new quotient bit enters at the bottom.
  always_comb begin
    trial    = {rem_r, dvd_r[frm_pkg::NUM_W-1]};
    fits     = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = frm_pkg::DIV_CNT_W'(frm_pkg::NUM_W);
      dvd_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = fits ? frm_pkg::SUM_W'(trial - {1'b0, den_r}) : trial[frm_pkg::SUM_W-1:0];
      dvd_nxt = {dvd_r[frm_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == frm_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for frame_rate_meter_limiter: frame events in, frame reports out.
// It holds its own model of the frame time ring, the rate average and the limiter.
// Depends on frm_pkg and the block's RTL only.
module tb_top;
  import frm_pkg::*;

  // Event kinds on in_func.
  typedef enum logic {
    FRAME_BEGIN = 1'b0,
    FRAME_END   = 1'b1
  } frame_event_t;

  // Register indexes. Index 1 holds nothing, so a write there must be dropped.
  localparam int REG_FPS_LIMIT = REG_MAX_FPS;
  localparam int REG_SPARE     = 1;

  // The settle pause is longer than the time a frame end takes to produce
  // its report after the transfer.
  localparam int SETTLE_CYCLES  = 2 * NUM_W + 16;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SHOWN_ERRORS   = 10;
  localparam int ITEMS_PER_STEP = 150;
  localparam int STEPS          = 8;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_ms;
    logic [FPS_W-1:0]   fps_q8;
    logic [DELAY_W-1:0] delay_ms;
  } frame_report_t;

  // Scoreboard: predicts each frame report from the accepted events and
  // checks the reports in order.
  class frame_scoreboard;
    frame_report_t       expected_reports[$];
    logic [FRAME_W-1:0]  ring_ms[SAMPLES];
    int unsigned         slot;
    int unsigned         filled;
    int unsigned         ring_total;
    logic [TICK_W-1:0]   prev_end_tick;
    logic [TICK_W-1:0]   busy_start_tick;
    bit                  end_seen;
    logic [MAXFPS_W-1:0] fps_limit;
    int unsigned         mismatches;

    function void clear();
      foreach (ring_ms[i]) ring_ms[i] = '0;
      slot            = 0;
      filled          = 0;
      ring_total      = 0;
      prev_end_tick   = '0;
      busy_start_tick = '0;
      end_seen        = 1'b0;
      fps_limit       = MAXFPS_W'(MAXFPS_RESET);
      expected_reports.delete();
    endfunction

    function void set_fps_limit(logic [PDATA_W-1:0] value);
      fps_limit = value[MAXFPS_W-1:0];
    endfunction

    function void record_mismatch(string msg);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) $display("%s", msg);
    endfunction

    function logic [FPS_W-1:0] average_rate();
      longint unsigned q;
      if (ring_total == 0) return FPS_W'(FPS_DEFAULT_Q8);
      q = FPS_MAX_Q8;
      q = q * filled / ring_total;
      if (q > FPS_MAX_Q8) q = FPS_MAX_Q8;
      return FPS_W'(q);
    endfunction

    function logic [DELAY_W-1:0] limit_delay(logic [TICK_W-1:0] busy);
      longint unsigned product;
      int unsigned     period;
      if (fps_limit == 0) return '0;
      product = busy;
      product = product * fps_limit;
      if (product >= MS_PER_S) return '0;
      period = MS_PER_S / fps_limit;
      return (period > busy) ? DELAY_W'(period - busy) : '0;
    endfunction

    function void note_event(frame_event_t kind, logic [TICK_W-1:0] tick);
      logic [TICK_W-1:0] elapsed;
      frame_report_t     report;
      if (kind == FRAME_BEGIN) begin
        busy_start_tick = tick;
        return;
      end
      elapsed = tick - prev_end_tick;
      if (!end_seen) begin
        report.frame_ms = '0;
      end else if (elapsed > (1 << FRAME_W) - 1) begin
        report.frame_ms = '1;
      end else begin
        report.frame_ms = elapsed[FRAME_W-1:0];
      end
      end_seen      = 1'b1;
      prev_end_tick = tick;
      ring_total    = ring_total - ring_ms[slot] + report.frame_ms;
      ring_ms[slot] = report.frame_ms;
      slot          = (slot + 1 >= SAMPLES) ? 0 : slot + 1;
      if (filled < SAMPLES) filled++;
      report.fps_q8   = average_rate();
      report.delay_ms = limit_delay(tick - busy_start_tick);
      expected_reports.push_back(report);
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t want;
      if (expected_reports.size() == 0) begin
        record_mismatch($sformatf("unexpected report: frame_ms=%0d fps_q8=%0d delay_ms=%0d",
                                  got.frame_ms, got.fps_q8, got.delay_ms));
        return;
      end
      want = expected_reports.pop_front();
      if (got.frame_ms !== want.frame_ms || got.fps_q8 !== want.fps_q8 ||
          got.delay_ms !== want.delay_ms) begin
        record_mismatch($sformatf(
          "report mismatch: expected frame_ms=%0d fps_q8=%0d delay_ms=%0d, got %0d %0d %0d",
          want.frame_ms, want.fps_q8, want.delay_ms,
          got.frame_ms, got.fps_q8, got.delay_ms));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = 1'b0;
  logic [TICK_W-1:0]   in_now_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FRAME_W-1:0]  out_frame_ms;
  logic [FPS_W-1:0]    out_fps_q8;
  logic [DELAY_W-1:0]  out_delay_ms;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [PDATA_W-1:0]  cfg_pwdata = '0;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  frame_scoreboard sb;

  // Idling knobs, changed only between steps.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Running millisecond tick used to build well-formed frame sequences.
  logic [TICK_W-1:0] tick_now = '0;

  // Values sampled at the falling edge, so the rising-edge processes see a
  // stable picture of what transfers at the next edge.
  logic          in_xfer = 1'b0;
  logic          out_xfer = 1'b0;
  logic          cfg_xfer = 1'b0;
  frame_report_t seen_report;
  logic [PDATA_W-1:0] seen_prdata;
  int unsigned   quiet_cycles = 0;

  frame_rate_meter_limiter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_now_ms    (in_now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_frame_ms (out_frame_ms),
    .out_fps_q8   (out_fps_q8),
    .out_delay_ms (out_delay_ms),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    in_xfer     = rst_n && in_valid && !in_stall;
    out_xfer    = rst_n && out_valid && !out_stall;
    cfg_xfer    = rst_n && cfg_psel && cfg_penable && cfg_pready;
    seen_report.frame_ms = out_frame_ms;
    seen_report.fps_q8   = out_fps_q8;
    seen_report.delay_ms = out_delay_ms;
    seen_prdata = cfg_prdata;
  end

  // Result side: random back-pressure, and every report transfer is checked
  // against the oldest prediction.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (out_xfer) sb.check_report(seen_report);
  end

  // Watchdog: a run that moves nothing on any port for too long has hung.
  always @(posedge clk) begin
    if (in_xfer || out_xfer || cfg_xfer) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one event. Before raising valid the sender may idle, and while it
  // idles the payload wanders so that only valid qualifies it. Returns at the
  // edge where the transfer happened, with valid still high; the caller either
  // offers the next event or lowers valid in that same step.
  task automatic send_event(input frame_event_t kind, input logic [TICK_W-1:0] tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      in_func   <= 1'($urandom_range(1));
      in_now_ms <= $urandom;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= kind;
    in_now_ms <= tick;
    @(posedge clk);
    while (!in_xfer) @(posedge clk);
    sb.note_event(kind, tick);
  endtask

  task automatic frame_pair(input logic [TICK_W-1:0] start, input int unsigned busy);
    send_event(FRAME_BEGIN, start);
    send_event(FRAME_END, start + busy);
  endtask

  // Drops valid, waits for every predicted report, then lets the block settle
  // so that a configuration write never lands while an event is in flight.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB access: setup cycle, then access cycle until pready. The bus is
  // left idle afterwards so back-to-back accesses never reassign psel twice
  // in one step.
  task automatic apb_access(input logic write, input int unsigned index,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= PADDR_W'(index * 4);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_xfer) @(posedge clk);
    rdata = seen_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_fps_limit();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, REG_FPS_LIMIT, '0, rd);
    if (rd !== PDATA_W'(sb.fps_limit))
      sb.record_mismatch($sformatf("max_fps readback: expected %0d, got %0d",
                                   sb.fps_limit, rd));
  endtask

  // Writes max_fps with random upper data bits, which the register must drop.
  task automatic write_fps_limit(input int unsigned fps);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] unused_rd;
    wdata = $urandom;
    wdata[MAXFPS_W-1:0] = MAXFPS_W'(fps);
    apb_access(1'b1, REG_FPS_LIMIT, wdata, unused_rd);
    sb.set_fps_limit(wdata);
    check_fps_limit();
  endtask

  // Random traffic. Most of it is begin/end pairs whose busy time sits around
  // the limiter period, so the delay is often non-zero; the rest is bursts of
  // ends without a begin and raw noise on both fields.
  task automatic run_frames(input int unsigned count);
    int unsigned sent;
    int unsigned roll;
    int unsigned busy;
    int unsigned gap;
    int unsigned period_hint;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_event(frame_event_t'($urandom_range(1)), $urandom);
        sent++;
      end else if (roll < 20) begin
        tick_now = tick_now + $urandom_range(3);
        send_event(FRAME_END, tick_now);
        sent++;
      end else begin
        period_hint = (sb.fps_limit == 0 || sb.fps_limit > MS_PER_S) ?
                      20 : MS_PER_S / sb.fps_limit + 2;
        busy = ($urandom_range(9) == 0) ? $urandom_range(3000) :
                                          $urandom_range(period_hint);
        gap  = ($urandom_range(19) == 0) ? $urandom_range(200000) : $urandom_range(40);
        // Now and then jump the tick, often to just below the wrap point.
        if ($urandom_range(49) == 0)
          tick_now = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(2000);
        frame_pair(tick_now, busy);
        tick_now = tick_now + busy + gap;
        sent += 2;
      end
    end
  endtask

  initial begin : stimulus
    logic [PDATA_W-1:0] unused_rd;
    int unsigned        fps_plan[STEPS];
    int unsigned        step;
    sb = new;
    sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_fps_limit();

    // Directed part at the reset limit of 60 fps.
    // An end with no begin measures busy time from tick zero; the first end
    // reports a zero frame time and, with an empty sum, the default rate.
    send_event(FRAME_END, 32'd5);
    send_event(FRAME_END, 32'd5);
    // A one-millisecond frame after zero-length ones: the rate saturates.
    send_event(FRAME_END, 32'd6);
    frame_pair(32'd10, 0);
    // Busy time equal to the period: no delay left.
    frame_pair(32'd20, 16);
    // A long pause saturates the frame time.
    send_event(FRAME_END, 32'd100_057);
    // Busy time that spans the tick wrap, then an end after the wrap.
    frame_pair(32'hFFFF_FFFE, 4);
    send_event(FRAME_END, 32'h0000_0000);
    quiesce();

    // Limiter extremes: the slowest and fastest legal limits, a zero limit
    // that switches the limiter off, and a limit above 1000.
    write_fps_limit(1);
    frame_pair(32'd1000, 0);
    frame_pair(32'd6000, 1000);
    quiesce();
    write_fps_limit(MS_PER_S);
    frame_pair(32'd8000, 0);
    frame_pair(32'd8010, 1);
    quiesce();
    write_fps_limit(0);
    frame_pair(32'd9000, 0);
    quiesce();
    write_fps_limit(1023);
    frame_pair(32'd9100, 0);
    quiesce();
    // A write to an index with no register must leave max_fps alone.
    apb_access(1'b1, REG_SPARE, 32'd7, unused_rd);
    check_fps_limit();

    // Random part: each step picks a limit and an idling pattern.
    fps_plan = '{MAXFPS_RESET, 1, MS_PER_S, 0, 1023, 1, 1, 144};
    fps_plan[5] = $urandom_range(1, MS_PER_S);
    fps_plan[6] = $urandom_range(1, 100);
    tick_now = 32'd20000;
    for (step = 0; step < STEPS; step++) begin
      quiesce();
      case (step % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 84;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 84;
        end
        default: begin
          send_idle_pct  <= 14;
          recv_stall_pct <= 14;
        end
      endcase
      write_fps_limit(fps_plan[step]);
      run_frames(ITEMS_PER_STEP);
    end

    quiesce();
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
